// ===== rtl/core/poly_voice_allocator_macros.svh =====
// Assertion shorthands for the allocator's top-level RTL file.
`ifndef POLY_VOICE_ALLOCATOR_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define PVA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PVA_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pva_pkg.sv =====
package pva_pkg;

   localparam int VOICES = 8;
   localparam int IDX_W = $clog2(VOICES);
   localparam int CNT_W = $clog2(VOICES + 1);
   localparam int IDX_SUM_W = CNT_W + 1;
   localparam int FUNC_W = 2;
   localparam int NOTE_W = 7;
   localparam int VOICE_FIELD_W = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_NOTE_ON     = 2'd0,
      FUNC_NOTE_OFF    = 2'd1,
      FUNC_SUSTAIN_ON  = 2'd2,
      FUNC_SUSTAIN_OFF = 2'd3
   } func_type;

   typedef enum logic {
      ACTION_STOP  = 1'b0,
      ACTION_START = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_START,
      ST_SWEEP
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT
   } cell_op_type;

   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic [IDX_W-1:0]  voice;
      logic              held;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      logic        clr_held;
   } cell_ctl_type;

   typedef struct packed {
      logic             pop;
      logic             push;
      logic [IDX_W-1:0] push_voice;
   } idle_ctl_type;

   typedef struct packed {
      logic [IDX_W-1:0] head_voice;
      logic [CNT_W-1:0] count;
   } idle_stat_type;

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [IDX_W-1:0] first_set(input logic [VOICES-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/core/pva_cell.sv =====
module pva_cell (
   input  logic                         clock,
   input  pva_pkg::cell_ctl_type        ctl,
   input  pva_pkg::entry_type           prev_entry,
   input  pva_pkg::entry_type           next_entry,
   input  logic [pva_pkg::NOTE_W-1:0]   key_note,
   output pva_pkg::entry_type           entry,
   output logic                         note_match,
   output logic                         released
);

   pva_pkg::entry_type entry_ff;
   pva_pkg::entry_type entry_in;

   always_comb begin
      case (ctl.op)
         pva_pkg::CELL_FROM_PREV: entry_in = prev_entry;
         pva_pkg::CELL_FROM_NEXT: entry_in = next_entry;
         default:                 entry_in = entry_ff;
      endcase
      if (ctl.clr_held) begin
         entry_in.held = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign note_match = (entry_ff.note == key_note);
   assign released   = !entry_ff.held;

endmodule

// ===== rtl/core/pva_idle_fifo.sv =====
module pva_idle_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  pva_pkg::idle_ctl_type   ctl,
   output pva_pkg::idle_stat_type  stat
);

   logic [pva_pkg::IDX_W-1:0]     queue_ff [pva_pkg::VOICES];
   logic [pva_pkg::IDX_W-1:0]     head_ff;
   logic [pva_pkg::IDX_W-1:0]     head_in;
   logic [pva_pkg::CNT_W-1:0]     count_ff;
   logic [pva_pkg::CNT_W-1:0]     count_in;
   logic [pva_pkg::IDX_SUM_W-1:0] tail_sum;
   logic [pva_pkg::IDX_W-1:0]     tail;

   always_comb begin
      tail_sum = pva_pkg::IDX_SUM_W'(head_ff) + pva_pkg::IDX_SUM_W'(count_ff);
      if (tail_sum >= pva_pkg::IDX_SUM_W'(pva_pkg::VOICES)) begin
         tail = pva_pkg::IDX_W'(tail_sum - pva_pkg::IDX_SUM_W'(pva_pkg::VOICES));
      end else begin
         tail = pva_pkg::IDX_W'(tail_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         if (head_ff == pva_pkg::IDX_W'(pva_pkg::VOICES - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + pva_pkg::IDX_W'(1);
         end
         count_in = count_ff - pva_pkg::CNT_W'(1);
      end else if (ctl.push) begin
         count_in = count_ff + pva_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= pva_pkg::CNT_W'(pva_pkg::VOICES);
         for (int i = 0; i < pva_pkg::VOICES; i++) begin
            queue_ff[i] <= pva_pkg::IDX_W'(i);
         end
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (ctl.push && !ctl.pop) begin
            queue_ff[tail] <= ctl.push_voice;
         end
      end
   end

   assign stat.head_voice = queue_ff[head_ff];
   assign stat.count      = count_ff;

endmodule

// ===== rtl/core/poly_voice_allocator.sv =====
// Voice allocator: each key or sustain event answers with zero or more voice commands, one
// word per command, with last set on the final one. The block takes one event at a time and
// holds req_stall high until the event's commands are all in the output register. An event
// is registered on entry and then decided, and a start after a retrigger or a steal passes
// through a further start state. A sustain-off walks the playing list one released voice per
// cycle while the output register can take a word. The playing list is a row of cells that
// shift toward the older end on a new note and toward the newer end when a voice leaves;
// free voices wait in a small FIFO.
module poly_voice_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pva_pkg::FUNC_W-1:0]        req_func,
   input  logic [pva_pkg::NOTE_W-1:0]        req_note,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_action,
   output logic [pva_pkg::VOICE_FIELD_W-1:0] rsp_voice,
   output logic [pva_pkg::NOTE_W-1:0]        rsp_voice_note,
   output logic                              rsp_last
);

`include "poly_voice_allocator_macros.svh"

   pva_pkg::state_type     state_ff;
   pva_pkg::state_type     state_in;
   pva_pkg::func_type      func_ff;
   logic [pva_pkg::NOTE_W-1:0] note_ff;
   logic [pva_pkg::CNT_W-1:0]  count_ff;
   logic [pva_pkg::CNT_W-1:0]  count_in;
   logic                       sustain_ff;
   logic                       sustain_in;
   logic [pva_pkg::IDX_W-1:0]  start_voice_ff;
   logic [pva_pkg::IDX_W-1:0]  start_voice_in;

   logic                                rsp_valid_ff;
   pva_pkg::action_type                 rsp_action_ff;
   logic [pva_pkg::VOICE_FIELD_W-1:0]   rsp_voice_ff;
   logic [pva_pkg::NOTE_W-1:0]          rsp_voice_note_ff;
   logic                                rsp_last_ff;

   pva_pkg::entry_type     cell_entry [pva_pkg::VOICES];
   pva_pkg::cell_ctl_type  cell_ctl   [pva_pkg::VOICES];
   logic [pva_pkg::VOICES-1:0] match_raw;
   logic [pva_pkg::VOICES-1:0] released_raw;
   logic [pva_pkg::VOICES-1:0] occupied;
   logic [pva_pkg::VOICES-1:0] note_hit;
   logic [pva_pkg::VOICES-1:0] cand;
   pva_pkg::entry_type     new_entry;

   pva_pkg::idle_ctl_type  idle_ctl;
   pva_pkg::idle_stat_type idle_stat;

   logic                       out_free;
   logic                       hit;
   logic                       idle_avail;
   logic                       sweep_last;
   logic [pva_pkg::IDX_W-1:0]  pos;
   logic [pva_pkg::IDX_W-1:0]  last_idx;
   logic [pva_pkg::IDX_W-1:0]  sel_idx;
   logic [pva_pkg::IDX_W-1:0]  sel_voice;

   logic                       ins_en;
   logic [pva_pkg::IDX_W-1:0]  ins_limit;
   logic                       rem_en;
   logic [pva_pkg::IDX_W-1:0]  rem_pos;
   logic                       clr_en;
   logic [pva_pkg::IDX_W-1:0]  new_voice;
   logic                       emit;
   pva_pkg::action_type        emit_action;
   logic [pva_pkg::IDX_W-1:0]  emit_voice;
   logic [pva_pkg::NOTE_W-1:0] emit_note;
   logic                       emit_last;

   assign new_entry = '{note: note_ff, voice: new_voice, held: 1'b1};

   for (genvar i = 0; i < pva_pkg::VOICES; i++) begin : g_cell
      pva_pkg::entry_type prev_entry;
      pva_pkg::entry_type next_entry;

      if (i == 0) begin : g_first
         assign prev_entry = new_entry;
      end else begin : g_inner
         assign prev_entry = cell_entry[i-1];
      end

      if (i == pva_pkg::VOICES - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_upper
         assign next_entry = cell_entry[i+1];
      end

      assign occupied[i] = (pva_pkg::CNT_W'(i) < count_ff);

      always_comb begin
         if (ins_en && (pva_pkg::IDX_W'(i) <= ins_limit)) begin
            cell_ctl[i].op = pva_pkg::CELL_FROM_PREV;
         end else if (rem_en && (pva_pkg::IDX_W'(i) >= rem_pos)) begin
            cell_ctl[i].op = pva_pkg::CELL_FROM_NEXT;
         end else begin
            cell_ctl[i].op = pva_pkg::CELL_HOLD;
         end
         cell_ctl[i].clr_held = clr_en && (pva_pkg::IDX_W'(i) == pos);
      end

      pva_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .key_note   (note_ff),
         .entry      (cell_entry[i]),
         .note_match (match_raw[i]),
         .released   (released_raw[i])
      );
   end

   pva_idle_fifo u_idle_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (idle_ctl),
      .stat  (idle_stat)
   );

   assign note_hit   = match_raw & occupied;
   assign cand       = released_raw & occupied;
   assign hit        = |note_hit;
   assign pos        = pva_pkg::first_set(note_hit);
   assign last_idx   = pva_pkg::IDX_W'(count_ff - pva_pkg::CNT_W'(1));
   assign idle_avail = (idle_stat.count != '0);
   assign sweep_last = ~|(cand & (cand - pva_pkg::VOICES'(1)));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (state_ff == pva_pkg::ST_SWEEP) begin
         sel_idx = pva_pkg::first_set(cand);
      end else if (hit) begin
         sel_idx = pos;
      end else begin
         sel_idx = last_idx;
      end
   end

   assign sel_voice = cell_entry[sel_idx].voice;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pva_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pva_pkg::ST_DECIDE;
            end
         end
         pva_pkg::ST_DECIDE: begin
            case (func_ff)
               pva_pkg::FUNC_NOTE_ON: begin
                  if (out_free) begin
                     state_in = (hit || !idle_avail) ? pva_pkg::ST_START : pva_pkg::ST_IDLE;
                  end
               end
               pva_pkg::FUNC_NOTE_OFF: begin
                  if (!hit || sustain_ff || out_free) begin
                     state_in = pva_pkg::ST_IDLE;
                  end
               end
               pva_pkg::FUNC_SUSTAIN_OFF: state_in = pva_pkg::ST_SWEEP;
               default:                   state_in = pva_pkg::ST_IDLE;
            endcase
         end
         pva_pkg::ST_START: begin
            if (out_free) begin
               state_in = pva_pkg::ST_IDLE;
            end
         end
         pva_pkg::ST_SWEEP: begin
            if (!(|cand) || (out_free && sweep_last)) begin
               state_in = pva_pkg::ST_IDLE;
            end
         end
         default: state_in = pva_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ins_en              = 1'b0;
      ins_limit           = pos;
      rem_en              = 1'b0;
      rem_pos             = pos;
      clr_en              = 1'b0;
      new_voice           = sel_voice;
      idle_ctl.pop        = 1'b0;
      idle_ctl.push       = 1'b0;
      idle_ctl.push_voice = sel_voice;
      emit                = 1'b0;
      emit_action         = pva_pkg::ACTION_STOP;
      emit_voice          = sel_voice;
      emit_note           = '0;
      emit_last           = 1'b1;
      count_in            = count_ff;
      sustain_in          = sustain_ff;
      start_voice_in      = start_voice_ff;
      case (state_ff)
         pva_pkg::ST_DECIDE: begin
            case (func_ff)
               pva_pkg::FUNC_NOTE_ON: begin
                  if (out_free) begin
                     ins_en = 1'b1;
                     emit   = 1'b1;
                     if (hit) begin
                        ins_limit      = pos;
                        emit_last      = 1'b0;
                        start_voice_in = sel_voice;
                     end else if (idle_avail) begin
                        new_voice    = idle_stat.head_voice;
                        idle_ctl.pop = 1'b1;
                        ins_limit    = pva_pkg::IDX_W'(count_ff);
                        count_in     = count_ff + pva_pkg::CNT_W'(1);
                        emit_action  = pva_pkg::ACTION_START;
                        emit_voice   = idle_stat.head_voice;
                        emit_note    = note_ff;
                     end else begin
                        ins_limit      = last_idx;
                        emit_last      = 1'b0;
                        start_voice_in = sel_voice;
                     end
                  end
               end
               pva_pkg::FUNC_NOTE_OFF: begin
                  if (hit && sustain_ff) begin
                     clr_en = 1'b1;
                  end else if (hit && out_free) begin
                     rem_en        = 1'b1;
                     count_in      = count_ff - pva_pkg::CNT_W'(1);
                     idle_ctl.push = 1'b1;
                     emit          = 1'b1;
                  end
               end
               pva_pkg::FUNC_SUSTAIN_ON:  sustain_in = 1'b1;
               pva_pkg::FUNC_SUSTAIN_OFF: sustain_in = 1'b0;
               default: ;
            endcase
         end
         pva_pkg::ST_START: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_action = pva_pkg::ACTION_START;
               emit_voice  = start_voice_ff;
               emit_note   = note_ff;
            end
         end
         pva_pkg::ST_SWEEP: begin
            if ((|cand) && out_free) begin
               rem_en        = 1'b1;
               rem_pos       = sel_idx;
               count_in      = count_ff - pva_pkg::CNT_W'(1);
               idle_ctl.push = 1'b1;
               emit          = 1'b1;
               emit_last     = sweep_last;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pva_pkg::ST_IDLE;
         count_ff     <= '0;
         sustain_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         sustain_ff <= sustain_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_voice_ff <= start_voice_in;
      if (req_valid && !req_stall) begin
         func_ff <= pva_pkg::func_type'(req_func);
         note_ff <= req_note;
      end
      if (emit) begin
         rsp_action_ff     <= emit_action;
         rsp_voice_ff      <= pva_pkg::VOICE_FIELD_W'(emit_voice);
         rsp_voice_note_ff <= emit_note;
         rsp_last_ff       <= emit_last;
      end
   end

   assign req_stall      = (state_ff != pva_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_voice      = rsp_voice_ff;
   assign rsp_voice_note = rsp_voice_note_ff;
   assign rsp_last       = rsp_last_ff;

   `PVA_ASSERT_ALWAYS(a_voices_conserved,
      (pva_pkg::IDX_SUM_W'(count_ff) + pva_pkg::IDX_SUM_W'(idle_stat.count))
         == pva_pkg::IDX_SUM_W'(pva_pkg::VOICES),
      "every voice must be either playing or idle")
   `PVA_ASSERT_ALWAYS(a_note_unique, $onehot0(note_hit),
      "a note may occupy at most one list entry")
   `PVA_ASSERT_IMPLIES(a_stop_before_start,
      (state_ff == pva_pkg::ST_START) && rsp_valid_ff, !rsp_last_ff,
      "a pending start must follow a stop word that is not last")
   `PVA_ASSERT_NEXT(a_accept_decides, req_valid && !req_stall,
      state_ff == pva_pkg::ST_DECIDE, "an accepted event must be decided in the next cycle")

endmodule
